/* hdl/semaphore_round_robin_scheduler_core_assert.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef SEMAPHORE_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`define SEMAPHORE_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every clock edge outside reset.
`define SRRS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
// Next-cycle implication.
`define SRRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define SRRS_ASSERT_IMPL(label, ante, cons)
`define SRRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/srrs_pkg.sv */
package srrs_pkg;

   localparam int MaxProcsDefault  = 8;
   localparam int NumSemsDefault   = 4;
   localparam int CountBitsDefault = 8;

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 8;
   localparam int NumInitRegs  = 4;

   localparam logic [7:0] InitResetA = 8'd1;
   localparam logic [7:0] InitResetB = 8'd0;
   localparam logic [7:0] InitResetC = 8'd0;
   localparam logic [7:0] InitResetD = 8'd0;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_WAIT   = 3'd1,
      OP_SIGNAL = 3'd2,
      OP_TICK   = 3'd3,
      OP_TERM   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_FULL     = 2'd1,
      ERR_NO_PROC  = 2'd2,
      ERR_SATURATE = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      PS_UNUSED  = 2'd0,
      PS_ACTIVE  = 2'd1,
      PS_BLOCKED = 2'd2,
      PS_DONE    = 2'd3
   } pst_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_PRED, ST_LINK_NEW, ST_LINK_PRED, ST_QSTART, ST_QWALK,
      ST_QLINK, ST_BLOCK, ST_NSTART, ST_NWALK, ST_NSELF, ST_SIG, ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      A_NOP, A_LATCH, A_ERR1, A_ERR2, A_ERR3, A_CREATE_FIRST, A_PRED_START,
      A_RING_STEP, A_LINK_NEW, A_LINK_PRED, A_DEC, A_INC, A_QCLEAR, A_QHEAD,
      A_QSTART, A_WAIT_STEP, A_QLINK, A_BLOCK, A_NSTART, A_NSTEP, A_SETCUR_RD,
      A_SETCUR_SELF, A_SIG_READ, A_SIG_WAKE, A_TERM, A_OUT
   } act_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [1:0] sem_index;
   } req_type;

   typedef struct packed {
      logic [2:0] current_process;
      logic       running;
      logic       switched;
      logic       halted;
      logic [2:0] affected_process;
      logic       affected_valid;
      logic [1:0] error_code;
   } rsp_type;

   typedef struct packed {
      act_type act;
      logic    stat_sel_rd;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       sem_ok;
      logic       full;
      logic       first;
      logic       cur_none;
      logic       stat_active;
      logic       cnt_zero;
      logic       cnt_max;
      logic       head_empty;
      logic       pred_end;
      logic       ring_go;
      logic       wait_end;
      logic       step_last;
      logic       step_done;
      logic       out_free;
   } sts_type;

endpackage

/* hdl/srrs_ctrl.sv */
module srrs_ctrl import srrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            case (sts.op)
               OP_CREATE: begin
                  if (!sts.full && !sts.first) state_in = ST_PRED;
               end
               OP_WAIT: begin
                  if (sts.sem_ok && !sts.cur_none && sts.stat_active && sts.cnt_zero)
                     state_in = ST_QSTART;
               end
               OP_SIGNAL: begin
                  if (sts.sem_ok && !sts.head_empty) state_in = ST_SIG;
               end
               OP_TICK: begin
                  if (!sts.cur_none) state_in = ST_NSTART;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_PRED: begin
            if (sts.pred_end || sts.step_last) state_in = ST_LINK_NEW;
         end
         ST_LINK_NEW:  state_in = ST_LINK_PRED;
         ST_LINK_PRED: state_in = ST_FINISH;
         ST_QSTART: begin
            state_in = sts.head_empty ? ST_BLOCK : ST_QWALK;
         end
         ST_QWALK: begin
            if (sts.wait_end || sts.step_last) state_in = ST_QLINK;
         end
         ST_QLINK:  state_in = ST_BLOCK;
         ST_BLOCK:  state_in = ST_NSTART;
         ST_NSTART: state_in = ST_NWALK;
         ST_NWALK: begin
            if (!sts.step_done && sts.ring_go) begin
               if (sts.stat_active) state_in = ST_FINISH;
            end else begin
               state_in = ST_NSELF;
            end
         end
         ST_NSELF: state_in = ST_FINISH;
         ST_SIG:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.act         = A_NOP;
      cmd.stat_sel_rd = (state_ff == ST_NWALK);
      req_stall       = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) cmd.act = A_LATCH;
         end
         ST_DECODE: begin
            case (sts.op)
               OP_CREATE: begin
                  if (sts.full) cmd.act = A_ERR1;
                  else if (sts.first) cmd.act = A_CREATE_FIRST;
                  else cmd.act = A_PRED_START;
               end
               OP_WAIT: begin
                  if (!sts.sem_ok) cmd.act = A_NOP;
                  else if (sts.cur_none || !sts.stat_active) cmd.act = A_ERR2;
                  else if (!sts.cnt_zero) cmd.act = A_DEC;
                  else cmd.act = A_QCLEAR;
               end
               OP_SIGNAL: begin
                  if (!sts.sem_ok) cmd.act = A_NOP;
                  else if (sts.head_empty) cmd.act = sts.cnt_max ? A_ERR3 : A_INC;
                  else cmd.act = A_SIG_READ;
               end
               OP_TICK: begin
                  if (sts.cur_none) cmd.act = A_ERR2;
               end
               OP_TERM: begin
                  cmd.act = sts.cur_none ? A_ERR2 : A_TERM;
               end
               default: cmd.act = A_NOP;
            endcase
         end
         ST_PRED: begin
            if (!sts.pred_end) cmd.act = A_RING_STEP;
         end
         ST_LINK_NEW:  cmd.act = A_LINK_NEW;
         ST_LINK_PRED: cmd.act = A_LINK_PRED;
         ST_QSTART: begin
            cmd.act = sts.head_empty ? A_QHEAD : A_QSTART;
         end
         ST_QWALK: begin
            if (!sts.wait_end) cmd.act = A_WAIT_STEP;
         end
         ST_QLINK:  cmd.act = A_QLINK;
         ST_BLOCK:  cmd.act = A_BLOCK;
         ST_NSTART: cmd.act = A_NSTART;
         ST_NWALK: begin
            if (!sts.step_done && sts.ring_go)
               cmd.act = sts.stat_active ? A_SETCUR_RD : A_NSTEP;
         end
         ST_NSELF: cmd.act = A_SETCUR_SELF;
         ST_SIG:   cmd.act = A_SIG_WAKE;
         ST_FINISH: begin
            if (sts.out_free) cmd.act = A_OUT;
         end
         default: cmd.act = A_NOP;
      endcase
   end

endmodule

/* hdl/srrs_dpath.sv */
module srrs_dpath import srrs_pkg::*; #(
   parameter int MAX_PROCS  = MaxProcsDefault,
   parameter int NUM_SEMS   = NumSemsDefault,
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  req_type                 req_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  logic                    csr_write_en,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_data,
   input  cmd_type                 cmd,
   output sts_type                 sts
);

   localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int SW  = IW + 1;
   localparam int SIW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam logic [SW-1:0] NONE = SW'(MAX_PROCS);
   localparam logic [SW-1:0] LAST = SW'(MAX_PROCS - 1);
   localparam logic [31:0] CMAX32 = (32'd1 << COUNT_BITS) - 32'd1;
   localparam logic [COUNT_BITS-1:0] CMAX = CMAX32[COUNT_BITS-1:0];

   function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [7:0] v);
      logic [31:0] w;
      w = {24'd0, v};
      return (w > CMAX32) ? CMAX : w[COUNT_BITS-1:0];
   endfunction

   function automatic logic [2:0] low3(input logic [SW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[2:0];
   endfunction

   logic [7:0]            init_ff   [NumInitRegs];
   pst_type               status_ff [MAX_PROCS];
   logic [COUNT_BITS-1:0] count_ff  [NUM_SEMS];
   logic [SW-1:0]         head_ff   [NUM_SEMS];
   logic [SW-1:0]         ring_mem_ff [MAX_PROCS];
   logic [SW-1:0]         wait_mem_ff [MAX_PROCS];
   logic [SW-1:0]         ring_rd_ff, wait_rd_ff;
   logic [SW-1:0]         cur_ff, used_ff, before_ff, p_ff, step_ff, aff_ff;
   logic [2:0]            op_ff;
   logic [1:0]            sem_ff;
   logic                  halted_ff, affv_ff;
   err_type               err_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [SIW-1:0] sidx;
   logic           sem_ok, cur_none, out_free;
   logic [SW-1:0]  anchor, nw, stat_addr, cur_in;
   logic           ring_we, ring_re, wait_we, wait_re;
   logic [IW-1:0]  ring_wa, ring_ra, wait_wa, wait_ra;
   logic [SW-1:0]  ring_wd, wait_wd;

   assign sem_ok   = ({30'd0, sem_ff} < 32'(NUM_SEMS));
   assign sidx     = sem_ok ? sem_ff[SIW-1:0] : '0;
   assign cur_none = (cur_ff >= NONE);
   assign anchor   = cur_none ? '0 : cur_ff;
   assign nw       = used_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign stat_addr = cmd.stat_sel_rd ? ring_rd_ff : cur_ff;

   assign sts.op          = op_ff;
   assign sts.sem_ok      = sem_ok;
   assign sts.full        = (used_ff >= NONE);
   assign sts.first       = (used_ff == '0);
   assign sts.cur_none    = cur_none;
   assign sts.stat_active = (stat_addr < NONE) && (status_ff[stat_addr[IW-1:0]] == PS_ACTIVE);
   assign sts.cnt_zero    = (count_ff[sidx] == '0);
   assign sts.cnt_max     = (count_ff[sidx] == CMAX);
   assign sts.head_empty  = (head_ff[sidx] >= NONE);
   assign sts.pred_end    = (ring_rd_ff >= NONE) || (ring_rd_ff == anchor);
   assign sts.ring_go     = (ring_rd_ff < NONE) && (ring_rd_ff != cur_ff);
   assign sts.wait_end    = (wait_rd_ff >= NONE);
   assign sts.step_last   = (step_ff == LAST);
   assign sts.step_done   = (step_ff == NONE);
   assign sts.out_free    = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next-active result when the ring walk comes back to the running slot.
   assign cur_in = sts.stat_active ? cur_ff : NONE;

   always_comb begin
      ring_we = 1'b0;
      ring_wa = '0;
      ring_wd = '0;
      ring_re = 1'b0;
      ring_ra = '0;
      wait_we = 1'b0;
      wait_wa = '0;
      wait_wd = NONE;
      wait_re = 1'b0;
      wait_ra = '0;
      case (cmd.act)
         A_CREATE_FIRST: begin
            ring_we = 1'b1;
            ring_wa = nw[IW-1:0];
            ring_wd = nw;
            wait_we = 1'b1;
            wait_wa = nw[IW-1:0];
         end
         A_PRED_START: begin
            ring_re = 1'b1;
            ring_ra = anchor[IW-1:0];
         end
         A_RING_STEP, A_NSTEP: begin
            ring_re = 1'b1;
            ring_ra = ring_rd_ff[IW-1:0];
         end
         A_NSTART: begin
            ring_re = 1'b1;
            ring_ra = cur_ff[IW-1:0];
         end
         A_LINK_NEW: begin
            ring_we = 1'b1;
            ring_wa = nw[IW-1:0];
            ring_wd = anchor;
         end
         A_LINK_PRED: begin
            ring_we = 1'b1;
            ring_wa = p_ff[IW-1:0];
            ring_wd = nw;
            wait_we = 1'b1;
            wait_wa = nw[IW-1:0];
         end
         A_QCLEAR: begin
            wait_we = 1'b1;
            wait_wa = cur_ff[IW-1:0];
         end
         A_QSTART, A_SIG_READ: begin
            wait_re = 1'b1;
            wait_ra = head_ff[sidx][IW-1:0];
         end
         A_WAIT_STEP: begin
            wait_re = 1'b1;
            wait_ra = wait_rd_ff[IW-1:0];
         end
         A_QLINK: begin
            wait_we = 1'b1;
            wait_wa = p_ff[IW-1:0];
            wait_wd = cur_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem_ff[ring_wa] <= ring_wd;
      if (ring_re) ring_rd_ff <= ring_mem_ff[ring_ra];
      if (wait_we) wait_mem_ff[wait_wa] <= wait_wd;
      if (wait_re) wait_rd_ff <= wait_mem_ff[wait_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff[0] <= InitResetA;
         init_ff[1] <= InitResetB;
         init_ff[2] <= InitResetC;
         init_ff[3] <= InitResetD;
         for (int i = 0; i < MAX_PROCS; i++) status_ff[i] <= PS_UNUSED;
         for (int i = 0; i < NUM_SEMS; i++) begin
            head_ff[i] <= NONE;
            case (i)
               0:       count_ff[i] <= sat_cnt(InitResetA);
               1:       count_ff[i] <= sat_cnt(InitResetB);
               2:       count_ff[i] <= sat_cnt(InitResetC);
               default: count_ff[i] <= sat_cnt(InitResetD);
            endcase
         end
         cur_ff       <= NONE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) init_ff[csr_index] <= csr_data;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (cmd.act)
            A_LATCH: begin
               op_ff     <= req_data.operation;
               sem_ff    <= req_data.sem_index;
               before_ff <= cur_ff;
               halted_ff <= 1'b0;
               affv_ff   <= 1'b0;
               aff_ff    <= '0;
               err_ff    <= ERR_NONE;
            end
            A_ERR1: err_ff <= ERR_FULL;
            A_ERR2: err_ff <= ERR_NO_PROC;
            A_ERR3: err_ff <= ERR_SATURATE;
            A_CREATE_FIRST: begin
               for (int i = 0; i < NUM_SEMS; i++) count_ff[i] <= sat_cnt(init_ff[i]);
               status_ff[nw[IW-1:0]] <= PS_ACTIVE;
               used_ff <= used_ff + SW'(1);
               if (cur_none) cur_ff <= nw;
               aff_ff  <= nw;
               affv_ff <= 1'b1;
            end
            A_PRED_START: begin
               p_ff    <= anchor;
               step_ff <= '0;
            end
            A_RING_STEP: begin
               p_ff    <= ring_rd_ff;
               step_ff <= step_ff + SW'(1);
            end
            A_LINK_PRED: begin
               status_ff[nw[IW-1:0]] <= PS_ACTIVE;
               used_ff <= used_ff + SW'(1);
               if (cur_none) cur_ff <= nw;
               aff_ff  <= nw;
               affv_ff <= 1'b1;
            end
            A_DEC: count_ff[sidx] <= count_ff[sidx] - COUNT_BITS'(1);
            A_INC: count_ff[sidx] <= count_ff[sidx] + COUNT_BITS'(1);
            A_QHEAD: head_ff[sidx] <= cur_ff;
            A_QSTART: begin
               p_ff    <= head_ff[sidx];
               step_ff <= '0;
            end
            A_WAIT_STEP: begin
               p_ff    <= wait_rd_ff;
               step_ff <= step_ff + SW'(1);
            end
            A_BLOCK: status_ff[cur_ff[IW-1:0]] <= PS_BLOCKED;
            A_NSTART: step_ff <= '0;
            A_NSTEP:  step_ff <= step_ff + SW'(1);
            A_SETCUR_RD: cur_ff <= ring_rd_ff;
            A_SETCUR_SELF: begin
               cur_ff    <= cur_in;
               halted_ff <= (cur_in >= NONE);
            end
            A_SIG_WAKE: begin
               status_ff[head_ff[sidx][IW-1:0]] <= PS_ACTIVE;
               head_ff[sidx] <= wait_rd_ff;
               aff_ff  <= head_ff[sidx];
               affv_ff <= 1'b1;
               if (cur_none) cur_ff <= head_ff[sidx];
            end
            A_TERM: status_ff[cur_ff[IW-1:0]] <= PS_DONE;
            A_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff.running          <= !cur_none;
               rsp_data_ff.current_process  <= cur_none ? 3'd0 : low3(cur_ff);
               rsp_data_ff.switched         <= (cur_ff != before_ff);
               rsp_data_ff.halted           <= halted_ff;
               rsp_data_ff.affected_process <= affv_ff ? low3(aff_ff) : 3'd0;
               rsp_data_ff.affected_valid   <= affv_ff;
               rsp_data_ff.error_code       <= err_ff;
            end
            default: ;
         endcase
      end
   end

endmodule

/* hdl/semaphore_round_robin_scheduler_core.sv */
// Channel  Ports                                      Direction  Transfer when
// req      req_valid, req_stall, req_data             in         req_valid && !req_stall
// rsp      rsp_valid, rsp_stall, rsp_data             out        rsp_valid && !rsp_stall
// csr      csr_write_en, csr_index, csr_data          in         csr_write_en
//
// One operation is in flight at a time. A wait can both walk a semaphore queue and
// search the ring; the single read port of each link memory lets the sequencer
// follow one link per cycle. Reset is synchronous and active high and needs no
// clearing pass. The result register lets a new request transfer while the
// previous result is still stalled.
module semaphore_round_robin_scheduler_core import srrs_pkg::*; #(
   parameter int MAX_PROCS  = MaxProcsDefault,
   parameter int NUM_SEMS   = NumSemsDefault,
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_write_en,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_data
);

`include "semaphore_round_robin_scheduler_core_assert.svh"

   // Command and status between the sequencer and the scheduler state.
   cmd_type cmd;
   sts_type sts;

   // The sequencer walks the ring and the wait queues one link per cycle.
   srrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds process status, links, semaphore counts and the result.
   srrs_dpath #(
      .MAX_PROCS  (MAX_PROCS),
      .NUM_SEMS   (NUM_SEMS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .sts          (sts)
   );

   // Once a request transfers, the block is busy in the cycle after.
   `SRRS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   // No running process means the reported slot is zero.
   `SRRS_ASSERT_IMPL(a_idle_slot, rsp_valid && !rsp_data.running, rsp_data.current_process == 3'd0)
   // A halt is always a switch away to nothing.
   `SRRS_ASSERT_IMPL(a_halt_switch, rsp_valid && rsp_data.halted,
                     rsp_data.switched && !rsp_data.running)

endmodule
